FILE: src/pndr_pkg.sv
// Shared types and constants for the Pareto front ranking block.
`timescale 1ns / 1ps
package pndr_pkg;

  localparam int NUM_OBJ       = 7;
  localparam int OBJ_SEL_W     = 3;
  localparam int RANK_W        = 6;
  localparam int POP_MAX_DEF   = 64;
  localparam int KEY_WIDTH_DEF = 32;

  typedef enum logic [3:0] {
    S_LOAD,
    S_WRITE,
    S_RDA,
    S_RDB,
    S_EV,
    S_ROWWR,
    S_PRD,
    S_PEV,
    S_PEND,
    S_ORD,
    S_OCAP,
    S_OWAIT
  } state_t;

  typedef struct packed {
    logic en;
    logic first;
  } cmp_ctrl_t;

endpackage

FILE: src/pndr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pndr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/pndr_cmp.sv
// Shared key comparator that accumulates better/worse flags over the objectives.
`timescale 1ns / 1ps
module pndr_cmp import pndr_pkg::*; #(
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic                 clk,
  input  cmp_ctrl_t            ctrl,
  input  logic [KEY_WIDTH-1:0] key_a,
  input  logic [KEY_WIDTH-1:0] key_b,
  output logic                 dom_now
);

  logic better_r, worse_r;
  logic lt, gt, better_nxt, worse_nxt;

  assign lt         = key_a < key_b;
  assign gt         = key_a > key_b;
  assign better_nxt = (better_r & ~ctrl.first) | lt;
  assign worse_nxt  = (worse_r & ~ctrl.first) | gt;
  assign dom_now    = better_nxt & ~worse_nxt;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      better_r <= better_nxt;
      worse_r  <= worse_nxt;
    end
  end

endmodule

FILE: src/pareto_nondominated_rank_top.sv
// Top level: loads a population, builds dominance rows and peels Pareto fronts.
// Load: an item is accepted, then its seven keys are written into the store before the next is taken.
// Ranking after the last item: pairwise compares (one shared comparator, read A, read B
//   and evaluate states per objective through one store read port, one row write per
//   candidate), then front peeling in rounds.
// Results: read, capture, then held in wait until out_ready. Sync active-low reset
//   empties the population; the stores need no clearing.
`timescale 1ns / 1ps
module pareto_nondominated_rank_top import pndr_pkg::*; #(
  parameter int POP_MAX   = POP_MAX_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_obj_coarseness,
  input  logic [31:0] in_obj_contrast,
  input  logic [31:0] in_obj_directionality,
  input  logic [31:0] in_obj_linelikeness,
  input  logic [31:0] in_obj_regularity,
  input  logic [31:0] in_obj_roughness,
  input  logic [31:0] in_obj_error,
  input  logic        in_last_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_item_index,
  output logic [5:0]  out_front_rank,
  output logic        out_last_result
);

  localparam int IDX_W = $clog2(POP_MAX);
  localparam int CNT_W = $clog2(POP_MAX + 1);
  localparam int OBJ_D = POP_MAX * NUM_OBJ;
  localparam int AW    = $clog2(OBJ_D);

  state_t state_r, state_nxt;

  logic [KEY_WIDTH-1:0] key_r [NUM_OBJ];
  logic                 last_r;
  logic [CNT_W-1:0]     loaded_r, n_r;
  logic [IDX_W-1:0]     i_r, j_r;
  logic [OBJ_SEL_W-1:0] k_r;
  logic [RANK_W-1:0]    round_r;
  logic [POP_MAX-1:0]   row_r, done_r, done_new_r, done_init;
  logic [KEY_WIDTH-1:0] key_a_r;
  logic [5:0]           out_idx_r, out_rank_r;
  logic                 out_last_r;

  // store ports
  logic                 obj_we;
  logic [AW-1:0]        obj_waddr, obj_raddr;
  logic [KEY_WIDTH-1:0] obj_wdata, obj_rdata;
  logic                 mat_we;
  logic [IDX_W-1:0]     mat_raddr;
  logic [POP_MAX-1:0]   mat_rdata;
  logic                 rank_we;
  logic [IDX_W-1:0]     rank_raddr;
  logic [RANK_W-1:0]    rank_rdata;

  cmp_ctrl_t cmp_ctrl;
  logic      dom_now;

  logic in_xfer, out_xfer, last_obj, i_end, j_end, pop_full, peel;

  assign in_xfer  = in_valid & in_ready;
  assign out_xfer = out_valid & out_ready;
  assign last_obj = k_r == OBJ_SEL_W'(NUM_OBJ - 1);
  assign i_end    = (CNT_W'(i_r) + CNT_W'(1)) == n_r;
  assign j_end    = (CNT_W'(j_r) + CNT_W'(1)) == n_r;
  assign pop_full = loaded_r == CNT_W'(POP_MAX);
  // a candidate joins this front when no candidate still unranked dominates it
  assign peel     = ~done_r[j_r] & ((mat_rdata & ~done_r) == '0);

  // slots beyond the population count as already ranked
  always_comb begin
    for (int b = 0; b < POP_MAX; b++) begin
      done_init[b] = CNT_W'(b) >= n_r;
    end
  end

  pndr_ram #(.WIDTH(KEY_WIDTH), .DEPTH(OBJ_D)) u_obj_ram (
    .clk  (clk),
    .we   (obj_we),
    .waddr(obj_waddr),
    .wdata(obj_wdata),
    .raddr(obj_raddr),
    .rdata(obj_rdata)
  );

  // row j holds one bit per candidate that dominates j
  pndr_ram #(.WIDTH(POP_MAX), .DEPTH(POP_MAX)) u_mat_ram (
    .clk  (clk),
    .we   (mat_we),
    .waddr(j_r),
    .wdata(row_r),
    .raddr(mat_raddr),
    .rdata(mat_rdata)
  );

  pndr_ram #(.WIDTH(RANK_W), .DEPTH(POP_MAX)) u_rank_ram (
    .clk  (clk),
    .we   (rank_we),
    .waddr(j_r),
    .wdata(round_r),
    .raddr(rank_raddr),
    .rdata(rank_rdata)
  );

  pndr_cmp #(.KEY_WIDTH(KEY_WIDTH)) u_cmp (
    .clk    (clk),
    .ctrl   (cmp_ctrl),
    .key_a  (key_a_r),
    .key_b  (obj_rdata),
    .dom_now(dom_now)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          if (!pop_full) begin
            state_nxt = S_WRITE;
          end else if (in_last_item) begin
            state_nxt = S_RDA;
          end
        end
      end
      S_WRITE: begin
        if (last_obj) state_nxt = last_r ? S_RDA : S_LOAD;
      end
      S_RDA: state_nxt = S_RDB;
      S_RDB: state_nxt = S_EV;
      S_EV: begin
        if (last_obj && i_end) state_nxt = S_ROWWR;
        else state_nxt = S_RDA;
      end
      S_ROWWR: state_nxt = j_end ? S_PRD : S_RDA;
      S_PRD:   state_nxt = S_PEV;
      S_PEV:   state_nxt = j_end ? S_PEND : S_PRD;
      S_PEND:  state_nxt = (&done_new_r) ? S_ORD : S_PRD;
      S_ORD:   state_nxt = S_OCAP;
      S_OCAP:  state_nxt = S_OWAIT;
      S_OWAIT: begin
        if (out_ready) state_nxt = out_last_r ? S_LOAD : S_ORD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // outputs and store controls
  always_comb begin
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    obj_we         = 1'b0;
    obj_waddr      = AW'(AW'(loaded_r) * AW'(NUM_OBJ) + AW'(k_r));
    obj_wdata      = key_r[k_r];
    obj_raddr      = '0;
    mat_we         = 1'b0;
    mat_raddr      = j_r;
    rank_we        = 1'b0;
    rank_raddr     = j_r;
    cmp_ctrl.en    = 1'b0;
    cmp_ctrl.first = k_r == '0;
    unique case (state_r)
      S_LOAD:  in_ready = 1'b1;
      S_WRITE: obj_we = 1'b1;
      S_RDA:   obj_raddr = AW'(AW'(i_r) * AW'(NUM_OBJ) + AW'(k_r));
      S_RDB:   obj_raddr = AW'(AW'(j_r) * AW'(NUM_OBJ) + AW'(k_r));
      S_EV:    cmp_ctrl.en = 1'b1;
      S_ROWWR: mat_we = 1'b1;
      S_PEV:   rank_we = peel;
      S_OWAIT: out_valid = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      loaded_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_WRITE && last_obj) begin
        loaded_r <= loaded_r + CNT_W'(1);
      end else if (state_r == S_OWAIT && out_ready && out_last_r) begin
        loaded_r <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_LOAD: begin
        key_r[0] <= KEY_WIDTH'(in_obj_coarseness);
        key_r[1] <= KEY_WIDTH'(in_obj_contrast);
        key_r[2] <= KEY_WIDTH'(in_obj_directionality);
        key_r[3] <= KEY_WIDTH'(in_obj_linelikeness);
        key_r[4] <= KEY_WIDTH'(in_obj_regularity);
        key_r[5] <= KEY_WIDTH'(in_obj_roughness);
        key_r[6] <= KEY_WIDTH'(in_obj_error);
        last_r   <= in_last_item;
        k_r      <= '0;
        i_r      <= '0;
        j_r      <= '0;
        row_r    <= '0;
        n_r      <= loaded_r;
      end
      S_WRITE: begin
        k_r <= last_obj ? '0 : k_r + OBJ_SEL_W'(1);
        n_r <= loaded_r + CNT_W'(1);
      end
      S_RDB: key_a_r <= obj_rdata;
      S_EV: begin
        if (last_obj) begin
          row_r[i_r] <= dom_now;
          k_r        <= '0;
          i_r        <= i_end ? '0 : i_r + IDX_W'(1);
        end else begin
          k_r <= k_r + OBJ_SEL_W'(1);
        end
      end
      S_ROWWR: begin
        row_r <= '0;
        if (j_end) begin
          j_r        <= '0;
          round_r    <= '0;
          done_r     <= done_init;
          done_new_r <= done_init;
        end else begin
          j_r <= j_r + IDX_W'(1);
        end
      end
      S_PEV: begin
        if (peel) done_new_r[j_r] <= 1'b1;
        j_r <= j_end ? '0 : j_r + IDX_W'(1);
      end
      S_PEND: begin
        done_r  <= done_new_r;
        round_r <= round_r + RANK_W'(1);
      end
      S_OCAP: begin
        out_idx_r  <= 6'(j_r);
        out_rank_r <= rank_rdata;
        out_last_r <= j_end;
      end
      S_OWAIT: begin
        if (out_ready) j_r <= j_r + IDX_W'(1);
      end
      default: ;
    endcase
  end

  assign out_item_index  = out_idx_r;
  assign out_front_rank  = out_rank_r;
  assign out_last_result = out_last_r;

  // the two channels are never open at the same time
  assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("input and result channels both active");

  // final result hands control back to loading
  assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_last_result |=> in_ready && loaded_r == '0)
    else $error("population not closed after last result");

  assert property (@(posedge clk) disable iff (!rst_n) loaded_r <= CNT_W'(POP_MAX))
    else $error("population count beyond capacity");

  // a transfer with a full store leaves the count unchanged
  assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && pop_full |=> loaded_r == CNT_W'(POP_MAX))
    else $error("overflow item was stored");

endmodule

FILE: tb/pareto_nondominated_rank_top_test.sv
// Testbench for the Pareto front ranking block: random populations, self-checked ranks.
`timescale 1ns / 1ps
module pareto_nondominated_rank_top_test;
  import pndr_pkg::*;

  localparam int POP_CAP = POP_MAX_DEF;

  // One candidate as the driver sends it.
  typedef struct packed {
    logic [NUM_OBJ-1:0][31:0] keys;
    logic                     last;
  } cand_t;

  // One front assignment as the block should report it.
  typedef struct packed {
    logic [5:0] idx;
    logic [5:0] rank;
    logic       last;
  } front_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [31:0] in_obj_coarseness;
  logic [31:0] in_obj_contrast;
  logic [31:0] in_obj_directionality;
  logic [31:0] in_obj_linelikeness;
  logic [31:0] in_obj_regularity;
  logic [31:0] in_obj_roughness;
  logic [31:0] in_obj_error;
  logic in_last_item;
  logic out_valid;
  logic out_ready;
  logic [5:0] out_item_index;
  logic [5:0] out_front_rank;
  logic out_last_result;

  cand_t  cand_q[$];      // candidates waiting to be driven
  front_t front_q[$];     // front assignments still owed by the block
  logic [NUM_OBJ-1:0][31:0] pop_keys[POP_CAP];
  int     pop_count;
  int     cand_total;
  int     cand_sent;
  int     in_gap;
  int     out_gap;
  int     fail_count;

  pareto_nondominated_rank_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_obj_coarseness(in_obj_coarseness),
    .in_obj_contrast(in_obj_contrast),
    .in_obj_directionality(in_obj_directionality),
    .in_obj_linelikeness(in_obj_linelikeness),
    .in_obj_regularity(in_obj_regularity),
    .in_obj_roughness(in_obj_roughness),
    .in_obj_error(in_obj_error),
    .in_last_item(in_last_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_item_index(out_item_index),
    .out_front_rank(out_front_rank),
    .out_last_result(out_last_result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly back-to-back, sometimes short pauses, rarely long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Narrow keys give ties and dominance; wide ones toggle every bit.
  function automatic logic [31:0] pick_key(int mode);
    int r;
    r = $urandom_range(99);
    if (mode == 0) return $urandom_range(3);
    if (r < 10) return 32'h0;
    if (r < 20) return 32'hffff_ffff;
    if (r < 60) return $urandom;
    return $urandom_range(7);
  endfunction

  function automatic cand_t make_cand(int mode, logic last);
    cand_t c;
    for (int k = 0; k < NUM_OBJ; k++) c.keys[k] = pick_key(mode);
    c.last = last;
    return c;
  endfunction

  function automatic cand_t fill_cand(logic [31:0] v, logic last);
    cand_t c;
    for (int k = 0; k < NUM_OBJ; k++) c.keys[k] = v;
    c.last = last;
    return c;
  endfunction

  // Append one candidate to the drive queue.
  task automatic queue_cand(cand_t c);
    cand_q.insert(cand_q.size(), c);
  endtask

  // Minimization: a beats b when no objective is worse and one is better.
  function automatic bit beats(int a, int b);
    bit better;
    bit worse;
    better = 0;
    worse  = 0;
    for (int k = 0; k < NUM_OBJ; k++) begin
      if (pop_keys[a][k] < pop_keys[b][k]) better = 1;
      else if (pop_keys[a][k] > pop_keys[b][k]) worse = 1;
    end
    return better && !worse;
  endfunction

  // Peel fronts of the current population and queue one assignment per candidate.
  task automatic peel_fronts();
    bit   beat_map[POP_CAP][POP_CAP];
    int   beaten_by[POP_CAP];
    bit   placed[POP_CAP];
    bit   peel[POP_CAP];
    int   rank_of[POP_CAP];
    int   left;
    int   front;
    front_t f;
    for (int i = 0; i < pop_count; i++) begin
      beaten_by[i] = 0;
      placed[i]    = 0;
      rank_of[i]   = 0;
    end
    for (int i = 0; i < pop_count; i++)
      for (int j = 0; j < pop_count; j++) begin
        beat_map[i][j] = (i != j) && beats(i, j);
        if (beat_map[i][j]) beaten_by[j]++;
      end
    left  = pop_count;
    front = 0;
    for (int r = 0; r < POP_CAP && left > 0; r++) begin
      for (int i = 0; i < pop_count; i++) begin
        peel[i] = !placed[i] && beaten_by[i] == 0;
        if (peel[i]) begin
          rank_of[i] = front;
          placed[i]  = 1;
          left--;
        end
      end
      for (int i = 0; i < pop_count; i++)
        if (peel[i])
          for (int j = 0; j < pop_count; j++)
            if (beat_map[i][j] && beaten_by[j] > 0) beaten_by[j]--;
      front = (front + 1) % 64;
    end
    for (int i = 0; i < pop_count; i++) begin
      f.idx  = i[5:0];
      f.rank = rank_of[i][5:0];
      f.last = (i + 1 == pop_count);
      front_q.insert(front_q.size(), f);
    end
  endtask

  // Model one accepted transfer.
  task automatic load_cand(cand_t c);
    if (pop_count < POP_CAP) begin
      pop_keys[pop_count] = c.keys;
      pop_count++;
    end
    if (c.last) begin
      peel_fronts();
      pop_count = 0;
    end
  endtask

  // Driver: valid holds steady until the transfer, then a random gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        load_cand({in_obj_coarseness, in_obj_contrast, in_obj_directionality,
                   in_obj_linelikeness, in_obj_regularity, in_obj_roughness,
                   in_obj_error, in_last_item});
        cand_sent++;
      end
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (cand_q.size() > 0) begin
        cand_t c;
        c = cand_q.pop_front();
        {in_obj_coarseness, in_obj_contrast, in_obj_directionality, in_obj_linelikeness,
         in_obj_regularity, in_obj_roughness, in_obj_error} <= c.keys;
        in_last_item <= c.last;
        in_valid     <= 1'b1;
        in_gap       <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result transfer against the oldest owed assignment.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap   <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (front_q.size() == 0) begin
          $error("unexpected result: item_index %0d front_rank %0d",
                 out_item_index, out_front_rank);
          fail_count++;
        end else begin
          front_t f;
          f = front_q.pop_front();
          if (out_item_index !== f.idx) begin
            $error("item_index: expected %0d, got %0d", f.idx, out_item_index);
            fail_count++;
          end
          if (out_front_rank !== f.rank) begin
            $error("front_rank: expected %0d, got %0d", f.rank, out_front_rank);
            fail_count++;
          end
          if (out_last_result !== f.last) begin
            $error("last_result: expected %0d, got %0d", f.last, out_last_result);
            fail_count++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap   <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap   <= pick_gap();
      end
    end
  end

  initial begin
    int n;
    int mode;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_obj_coarseness = '0;
    in_obj_contrast = '0;
    in_obj_directionality = '0;
    in_obj_linelikeness = '0;
    in_obj_regularity = '0;
    in_obj_roughness = '0;
    in_obj_error = '0;
    in_last_item = 1'b0;
    pop_count = 0;
    cand_sent = 0;
    fail_count = 0;

    // Directed: lone candidate, extremes, equal pair, strict chain, one-objective win.
    queue_cand(fill_cand(32'h0, 1'b1));
    queue_cand(fill_cand(32'hffff_ffff, 1'b0));
    queue_cand(fill_cand(32'h0, 1'b1));
    queue_cand(fill_cand(32'h5555_aaaa, 1'b0));
    queue_cand(fill_cand(32'h5555_aaaa, 1'b1));
    queue_cand(fill_cand(32'd3, 1'b0));
    queue_cand(fill_cand(32'd2, 1'b0));
    queue_cand(fill_cand(32'd1, 1'b0));
    queue_cand(fill_cand(32'd0, 1'b1));
    begin
      cand_t c;
      c = fill_cand(32'd9, 1'b0);
      queue_cand(c);
      c.keys[6] = 32'd8;
      queue_cand(c);
      c.keys[0] = 32'd10;
      c.last = 1'b1;
      queue_cand(c);
    end
    for (int i = 0; i < 6; i++) queue_cand(make_cand(1, i == 5));

    // A full population, then an overflowing one whose two final items, the closing one included, are dropped.
    for (int i = 0; i < POP_CAP; i++) queue_cand(make_cand(0, i == POP_CAP - 1));
    for (int i = 0; i < POP_CAP + 2; i++) queue_cand(make_cand(0, i == POP_CAP + 1));

    // Mostly small random populations.
    while (cand_q.size() < 270) begin
      n = $urandom_range(8, 1);
      mode = $urandom_range(1);
      for (int i = 0; i < n; i++) queue_cand(make_cand(mode, i == n - 1));
    end
    cand_total = cand_q.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    wait (cand_sent == cand_total && front_q.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: two full populations plus many small ones, with large margin.
  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
